[hw/rtl/cpa_pkg.sv]
// Package for the cosine pipeline: formats, fixed-point constants, stage counts.
// No dependencies; every other file in hw/rtl imports it.
package cpa_pkg;

  // Field widths
  localparam int ANGLE_W         = 32;
  localparam int ANGLE_FRAC_BITS = 24;   // Q7.24
  localparam int COS_W           = 18;   // Q1.16 result

  // Range reduction: turns = |angle| * 1/(2pi), Q0.32 constant
  localparam int INV_W = 30;
  localparam logic [INV_W-1:0] INV2PI_Q32 = 30'd683565276;
  localparam int PROD_TURN_W = ANGLE_W + INV_W;

  // 2pi in Q3.29
  localparam int TWOPI_W = 32;
  localparam logic [TWOPI_W-1:0] TWOPI_Q29 = 32'd3373259426;

  // Radian and square formats (Q2.30 and Q4.28)
  localparam int X_W = 32;
  localparam int Y_W = 32;
  localparam int X_SHIFT = 31;
  localparam int Y_SHIFT = 32;

  // Horner accumulator, signed Q.32
  localparam int ACC_W         = 40;
  localparam int MAG_W         = 34;
  localparam int HORNER_SHIFT  = 28;
  localparam int HORNER_STEPS  = 5;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [Y_W-1:0]          y_t;

  localparam acc_t C10 = -40'sd1184;
  localparam acc_t C8  = 40'sd106522;
  localparam acc_t C6  = -40'sd5965232;
  localparam acc_t C4  = 40'sd178956971;
  localparam acc_t C2  = -40'sd2147483648;
  localparam acc_t C0  = 40'sd4294967296;

  localparam acc_t HORNER_COEF [HORNER_STEPS] = '{C10, C8, C6, C4, C2};

  // Output rounding
  localparam int OUT_SHIFT = 16;
  localparam logic [ACC_W-1:0] ROUND_HALF = 40'h80_00;
  localparam logic [COS_W-1:0] COS_ONE    = 18'd65536;

  // Pipeline layout
  localparam int RED_STAGES  = 5;
  localparam int STEP_STAGES = 2;
  localparam int OUT_STAGES  = 2;
  localparam int N_STAGES    = RED_STAGES + HORNER_STEPS * STEP_STAGES + OUT_STAGES;

endpackage

[hw/rtl/cpa_reduce.sv]
// Range reduction front end: |angle| -> turn fraction -> fold -> x -> y = x^2.
// Five register stages, one enable each. Depends on cpa_pkg.
module cpa_reduce import cpa_pkg::*; (
  input  logic                         clk,
  input  logic [RED_STAGES-1:0]        en,
  input  logic signed [ANGLE_W-1:0]    angle,
  output y_t                           y
);

  logic [ANGLE_W-1:0]      mag_r, mag_nxt;
  logic [31:0]             m_r, m_nxt;
  logic [31:0]             mf_r, mf_nxt;
  logic [X_W-1:0]          x_r, x_nxt;
  y_t                      y_r, y_nxt;

  logic [ANGLE_W:0]        neg_full;
  logic [PROD_TURN_W-1:0]  p_turn;
  logic [32:0]             fold_full;
  logic [63:0]             p_rad;
  logic [63:0]             p_sq;

  // stage 0: magnitude (most negative angle gives 2^31 exactly)
  assign neg_full = {1'b1, {ANGLE_W{1'b0}}} - {1'b0, angle};
  assign mag_nxt  = angle[ANGLE_W-1] ? neg_full[ANGLE_W-1:0] : angle;

  // stage 1: fraction of a turn
  assign p_turn = mag_r * INV2PI_Q32;
  assign m_nxt  = p_turn[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];

  // stage 2: fold beyond half a turn
  assign fold_full = 33'h1_0000_0000 - {1'b0, m_r};
  assign mf_nxt    = (m_r > 32'h8000_0000) ? fold_full[31:0] : m_r;

  // stage 3: back to radians
  assign p_rad = mf_r * TWOPI_Q29;
  assign x_nxt = p_rad[X_SHIFT+X_W-1:X_SHIFT];

  // stage 4: square
  assign p_sq  = x_r * x_r;
  assign y_nxt = p_sq[Y_SHIFT+Y_W-1:Y_SHIFT];

  always_ff @(posedge clk) begin
    if (en[0]) mag_r <= mag_nxt;
    if (en[1]) m_r   <= m_nxt;
    if (en[2]) mf_r  <= mf_nxt;
    if (en[3]) x_r   <= x_nxt;
    if (en[4]) y_r   <= y_nxt;
  end

  assign y = y_r;

endmodule

[hw/rtl/cpa_hstep.sv]
// One Horner step: acc_out = trunc((acc_in + coef) * y >> 28), sign-magnitude.
// Two register stages (add/abs, multiply). Depends on cpa_pkg.
module cpa_hstep import cpa_pkg::*; (
  input  logic                    clk,
  input  logic [STEP_STAGES-1:0]  en,
  input  acc_t                    acc_in,
  input  acc_t                    coef,
  input  y_t                      y_in,
  output acc_t                    acc_out,
  output y_t                      y_out
);

  localparam int PROD_W = MAG_W + Y_W;
  localparam int SH_W   = PROD_W - HORNER_SHIFT;

  logic              neg_r, neg_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  y_t                ya_r, yb_r;
  acc_t              acc_r, acc_nxt;

  acc_t              sum;
  acc_t              abs_sum;
  logic [PROD_W-1:0] prod;
  acc_t              prod_ext;

  assign sum     = acc_in + coef;
  assign neg_nxt = sum[ACC_W-1];
  assign abs_sum = neg_nxt ? -sum : sum;
  assign mag_nxt = abs_sum[MAG_W-1:0];

  // magnitude truncates toward zero, sign reapplied after
  assign prod     = mag_r * ya_r;
  assign prod_ext = acc_t'({{(ACC_W-SH_W){1'b0}}, prod[PROD_W-1:HORNER_SHIFT]});
  assign acc_nxt  = neg_r ? -prod_ext : prod_ext;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
      ya_r  <= y_in;
    end
    if (en[1]) begin
      acc_r <= acc_nxt;
      yb_r  <= ya_r;
    end
  end

  assign acc_out = acc_r;
  assign y_out   = yb_r;

endmodule

[hw/rtl/cpa_outfmt.sv]
// Output stage: add the constant term, round half away from zero to Q1.16, clamp.
// Two register stages; the second is the output register. Depends on cpa_pkg.
module cpa_outfmt import cpa_pkg::*; (
  input  logic                   clk,
  input  logic [OUT_STAGES-1:0]  en,
  input  acc_t                   acc_in,
  output logic signed [COS_W-1:0] cosine
);

  localparam int Q_W = ACC_W - OUT_SHIFT;

  logic              neg_r, neg_nxt;
  logic [ACC_W-1:0]  mag_r, mag_nxt;
  logic signed [COS_W-1:0] cos_r, cos_nxt;

  acc_t              fin;
  acc_t              abs_fin;
  logic [ACC_W-1:0]  rnd;
  logic [Q_W-1:0]    q;
  logic [COS_W-1:0]  sat;

  assign fin     = acc_in + C0;
  assign neg_nxt = fin[ACC_W-1];
  assign abs_fin = neg_nxt ? -fin : fin;
  assign mag_nxt = abs_fin;

  assign rnd = mag_r + ROUND_HALF;
  assign q   = rnd[ACC_W-1:OUT_SHIFT];
  assign sat = (q > Q_W'(COS_ONE)) ? COS_ONE : q[COS_W-1:0];
  assign cos_nxt = neg_r ? -$signed(sat) : $signed(sat);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
    end
    if (en[1]) cos_r <= cos_nxt;
  end

  assign cosine = cos_r;

endmodule

[hw/rtl/cosine_poly_approx.sv]
// Cosine of a Q7.24 radian angle via range reduction and a degree-10 even polynomial.
// Top level: stage valid/enable control; uses cpa_reduce, cpa_hstep, cpa_outfmt, cpa_pkg.
//
// Usage:
//   Input channel: in_angle (signed Q7.24 radians) and in_last_in, taken on a rising
//   edge with in_valid high and in_stall low.
//   Output channel: out_cosine (signed Q1.16, clamped to +/-1.0) and out_last_out,
//   taken on a rising edge with out_valid high and out_stall low.
//   Stages: 17 register stages, 5 for range reduction, 2 for each of the 5 Horner
//   steps and 2 for rounding/clamp; the last one is the output register.
//   Throughput: one item per cycle while the output is not stalled. Each stage holds
//   at most one item and its multiplier is used once per item.
//   Stall: each stage advances when the stage after it is empty or advancing, so
//   bubbles squeeze out while out_stall is high; in_stall rises only when all 17
//   stages hold items and the output is stalled. A stalled result holds.
//   Reset: synchronous, active low; clears the stage valid bits only, so the
//   pipeline comes up empty and ready. There is no configuration or stored state.
module cosine_poly_approx import cpa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic                      in_last_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COS_W-1:0]   out_cosine,
  output logic                      out_last_out
);

  localparam int H_BASE = RED_STAGES;
  localparam int O_BASE = RED_STAGES + HORNER_STEPS * STEP_STAGES;

  logic [N_STAGES-1:0] v_r, v_nxt;
  logic [N_STAGES-1:0] last_r, last_nxt;
  logic [N_STAGES-1:0] en;

  y_t   y_chain   [HORNER_STEPS+1];
  acc_t acc_chain [HORNER_STEPS+1];

  // Per-stage enable: a stage loads when it is empty or its successor moves on.
  always_comb begin
    en[N_STAGES-1] = !v_r[N_STAGES-1] || !out_stall;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // Valid and last bits move with the data.
  always_comb begin
    v_nxt[0]    = en[0] ? in_valid   : v_r[0];
    last_nxt[0] = en[0] ? in_last_in : last_r[0];
    for (int k = 1; k < N_STAGES; k++) begin
      v_nxt[k]    = en[k] ? v_r[k-1]    : v_r[k];
      last_nxt[k] = en[k] ? last_r[k-1] : last_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

  assign in_stall     = !en[0];
  assign out_valid    = v_r[N_STAGES-1];
  assign out_last_out = last_r[N_STAGES-1];

  // Range reduction and square
  cpa_reduce u_reduce (
    .clk   (clk),
    .en    (en[RED_STAGES-1:0]),
    .angle (in_angle),
    .y     (y_chain[0])
  );

  // Horner chain; the first step starts from zero and adds c10
  assign acc_chain[0] = '0;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    cpa_hstep u_step (
      .clk     (clk),
      .en      (en[H_BASE + i*STEP_STAGES +: STEP_STAGES]),
      .acc_in  (acc_chain[i]),
      .coef    (HORNER_COEF[i]),
      .y_in    (y_chain[i]),
      .acc_out (acc_chain[i+1]),
      .y_out   (y_chain[i+1])
    );
  end

  // Constant term, rounding, clamp; y past the last step is not needed
  cpa_outfmt u_outfmt (
    .clk    (clk),
    .en     (en[O_BASE +: OUT_STAGES]),
    .acc_in (acc_chain[HORNER_STEPS]),
    .cosine (out_cosine)
  );

`ifndef ASSERT_OFF
  // Input may only back up when every stage is occupied and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // A free output never backs up the input.
  a_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  // An accepted item enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted item lost at pipeline entry");

  // A delivered result frees the output stage or is replaced by the next one.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v_r[N_STAGES-2]) |=> !out_valid)
    else $error("result repeated after delivery");
`endif

endmodule
